/* rtl/one_time_code_table_with_expiry_macros.svh */
// assertion macros for the one-time code table
`ifndef ONE_TIME_CODE_TABLE_WITH_EXPIRY_MACROS_SVH
`define ONE_TIME_CODE_TABLE_WITH_EXPIRY_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define OTC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define OTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OTC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define OTC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/otc_pkg.sv */
// shared types, codes and constants of the one-time code table
`default_nettype none
package otc_pkg;

  // table and field sizes
  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int CODE_SYMBOLS        = 8;
  localparam int CODE_W              = 40;
  localparam int CODE_BITS           = 5 * CODE_SYMBOLS;
  localparam logic [CODE_W-1:0] CODE_MASK =
    (CODE_BITS >= CODE_W) ? {CODE_W{1'b1}} : ((CODE_W'(1) << CODE_BITS) - CODE_W'(1));
  localparam logic [31:0] DEFAULT_LIFETIME = 32'd3600;
  localparam logic [4:0]  COUNT_MAX        = 5'd31;

  // register map
  localparam int   ADDR_W           = 3;
  localparam logic REG_LIFETIME_IDX = 1'b0;

  // command codes
  localparam logic [2:0] CMD_GENERATE = 3'd0;
  localparam logic [2:0] CMD_ACCEPT   = 3'd1;
  localparam logic [2:0] CMD_STATUS   = 3'd2;
  localparam logic [2:0] CMD_CLEANUP  = 3'd3;
  localparam logic [2:0] CMD_COUNT    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FREE   = 3'd1;
  localparam logic [2:0] ST_USED      = 3'd2;
  localparam logic [2:0] ST_EXPIRED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // input item
  typedef struct packed {
    logic [2:0]        command;
    logic [CODE_W-1:0] code_symbols;
    logic [2:0]        channel;
    logic [31:0]       now_seconds;
  } in_t;

  // result item
  typedef struct packed {
    logic [2:0] status;
    logic       code_live;
    logic       is_used;
    logic [4:0] pending_count;
  } out_t;

  // one slot of the code memory
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [2:0]        channel;
    logic [32:0]       expiry;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/otc_ctrl.sv */
// sequencer for load, slot scan and result hand-off
`default_nettype none
`include "one_time_code_table_with_expiry_macros.svh"
module otc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire otc_pkg::dp_sts_t  sts,
  output otc_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `OTC_ASSERT_NEXT(a_load_scans, clk, rst, cmd_valid && cmd_ready, state == ST_SCAN)
  `OTC_ASSERT_IMPL(a_finish_free, clk, rst, cmd.finish, sts.out_free)
  `OTC_ASSERT_NEXT(a_done_leaves, clk, rst, state == ST_DONE && sts.out_free, state == ST_IDLE)

endmodule
`default_nettype wire

/* rtl/otc_dp.sv */
// slot table, scan evaluation and result register
`default_nettype none
`include "one_time_code_table_with_expiry_macros.svh"
module otc_dp #(
  parameter int TABLE_DEPTH = otc_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire otc_pkg::in_t       cmd_item,
  input  wire logic [31:0]        lifetime,
  input  wire otc_pkg::ctrl_cmd_t cmd,
  output otc_pkg::dp_sts_t        sts,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output otc_pkg::out_t           rsp_item
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // captured item
  logic [2:0]                 cmd_q;
  logic [otc_pkg::CODE_W-1:0] code_q;
  logic [2:0]                 chan_q;
  logic [31:0]                now_q;
  logic [32:0]                exp_q;

  // slot flags and code memory
  logic [TABLE_DEPTH-1:0] present;
  logic [TABLE_DEPTH-1:0] used;
  otc_pkg::entry_t        mem [TABLE_DEPTH];
  otc_pkg::entry_t        rd_q;
  otc_pkg::entry_t        wr_entry;

  // scan state
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] eval_idx;
  logic             eval_vld;
  logic             eval_en;
  logic             mem_we;
  logic             match;
  logic             expired;

  // per-item results
  logic       found;
  logic [2:0] hit_st;
  logic       hit_valid;
  logic       hit_used;
  logic [4:0] cnt;
  otc_pkg::out_t result;

  // evaluation of the entry read last cycle
  always_comb begin
    eval_en  = cmd.scan && eval_vld;
    match    = present[eval_idx] && (rd_q.code == code_q);
    expired  = {1'b0, now_q} > rd_q.expiry;
    mem_we   = eval_en && (cmd_q == otc_pkg::CMD_GENERATE) && !found && !present[eval_idx];
    wr_entry = '{code: code_q, channel: chan_q, expiry: exp_q};
    sts.last     = eval_vld && (eval_idx == LAST_IDX);
    sts.out_free = !rsp_valid || rsp_ready;
  end

  // code memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[eval_idx] <= wr_entry;
    end
    rd_q <= mem[rd_addr];
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= cmd_item.command;
      code_q <= cmd_item.code_symbols & otc_pkg::CODE_MASK;
      chan_q <= cmd_item.channel;
      now_q  <= cmd_item.now_seconds;
      exp_q  <= {1'b0, cmd_item.now_seconds} + {1'b0, lifetime};
    end
  end

  // scan control, slot flags and per-item results
  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      used      <= '0;
      eval_vld  <= 1'b0;
      rd_addr   <= '0;
      eval_idx  <= '0;
      found     <= 1'b0;
      hit_st    <= otc_pkg::ST_OK;
      hit_valid <= 1'b0;
      hit_used  <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.load) begin
        eval_vld  <= 1'b0;
        rd_addr   <= '0;
        found     <= 1'b0;
        hit_st    <= otc_pkg::ST_OK;
        hit_valid <= 1'b0;
        hit_used  <= 1'b0;
        cnt       <= '0;
      end
      if (cmd.scan) begin
        eval_vld <= 1'b1;
        rd_addr  <= rd_addr + 1'b1;
        eval_idx <= rd_addr;
      end
      if (eval_en) begin
        case (cmd_q)
          otc_pkg::CMD_GENERATE: begin
            if (mem_we) begin
              present[eval_idx] <= 1'b1;
              used[eval_idx]    <= 1'b0;
              found             <= 1'b1;
            end
          end
          otc_pkg::CMD_ACCEPT: begin
            if (!found && match) begin
              found <= 1'b1;
              if (used[eval_idx]) begin
                hit_st <= otc_pkg::ST_USED;
              end else if (expired) begin
                present[eval_idx] <= 1'b0;
                hit_st            <= otc_pkg::ST_EXPIRED;
              end else begin
                used[eval_idx] <= 1'b1;
                hit_st         <= otc_pkg::ST_OK;
              end
            end
          end
          otc_pkg::CMD_STATUS: begin
            if (!found && match) begin
              found     <= 1'b1;
              hit_valid <= !expired;
              hit_used  <= used[eval_idx];
            end
          end
          otc_pkg::CMD_CLEANUP: begin
            if (present[eval_idx] && (used[eval_idx] || expired)) begin
              present[eval_idx] <= 1'b0;
            end
          end
          otc_pkg::CMD_COUNT: begin
            if (present[eval_idx] && (rd_q.channel == chan_q) && !used[eval_idx] &&
                !expired && (cnt != otc_pkg::COUNT_MAX)) begin
              cnt <= cnt + 5'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // final result of the item
  always_comb begin
    result               = '0;
    result.code_live     = hit_valid;
    result.is_used       = hit_used;
    result.pending_count = cnt;
    case (cmd_q)
      otc_pkg::CMD_GENERATE: result.status = found ? otc_pkg::ST_OK : otc_pkg::ST_NO_FREE;
      otc_pkg::CMD_ACCEPT:   result.status = found ? hit_st : otc_pkg::ST_NOT_FOUND;
      otc_pkg::CMD_STATUS:   result.status = found ? otc_pkg::ST_OK : otc_pkg::ST_NOT_FOUND;
      default:               result.status = otc_pkg::ST_OK;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_item <= result;
    end
  end

  `OTC_ASSERT_IMPL(a_one_new_slot, clk, rst, 1'b1, $countones(present) <= $countones($past(present)) + 1)
  `OTC_ASSERT_IMPL(a_cleanup_frees_only, clk, rst, cmd_q == otc_pkg::CMD_CLEANUP, (present & ~$past(present)) == '0)

endmodule
`default_nettype wire

/* rtl/one_time_code_table_with_expiry.sv */
// An item is captured, then the slot scan reads and checks one entry of the code memory
// per cycle, and the result goes to the output register once that is free; the block
// takes no new item until the result of the last one has gone to the output register.
// The item input takes a new item while a finished result waits to be taken.
// Reset (rst, synchronous): all slots free and unused, lifetime = 3600 s;
// code memory contents are not cleared and need no clearing pass.
`default_nettype none
module one_time_code_table_with_expiry #(
  parameter int TABLE_DEPTH = otc_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cmd_valid,
  output logic                            cmd_ready,
  input  wire otc_pkg::in_t               cmd_item,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output otc_pkg::out_t                   rsp_item,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [otc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [31:0]        lifetime;
  logic               reg_sel;
  otc_pkg::ctrl_cmd_t cmd;
  otc_pkg::dp_sts_t   sts;

  // register decode and read-back
  always_comb begin
    reg_sel = (paddr[otc_pkg::ADDR_W-1] == otc_pkg::REG_LIFETIME_IDX);
    prdata  = reg_sel ? lifetime : '0;
    pready  = 1'b1;
  end

  // lifetime register
  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= otc_pkg::DEFAULT_LIFETIME;
    end else if (psel && penable && pwrite && reg_sel) begin
      lifetime <= pwdata;
    end
  end

  otc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  otc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd_item  (cmd_item),
    .lifetime  (lifetime),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_one_time_code_table_with_expiry.sv */
// testbench for the one-time code table: directed and random commands checked against a slot-table predictor
`default_nettype none
module tb_one_time_code_table_with_expiry;

  localparam int CLK_PERIOD = 12;
  localparam int SLOTS      = otc_pkg::DEFAULT_TABLE_DEPTH;
  localparam int DRAIN      = SLOTS + 3;
  localparam int POOL       = 24;
  localparam int PHASE_LEN  = 250;
  localparam int CW         = otc_pkg::CODE_W;
  localparam int AW         = otc_pkg::ADDR_W;
  localparam logic [AW-1:0] LIFETIME_ADDR = AW'(4 * otc_pkg::REG_LIFETIME_IDX);

  // ports
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  otc_pkg::in_t      cmd_item = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  otc_pkg::out_t     rsp_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AW-1:0]     paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predicted table contents
  logic              slot_live [SLOTS];
  logic              slot_used [SLOTS];
  logic [CW-1:0]     slot_code [SLOTS];
  logic [2:0]        slot_chan [SLOTS];
  logic [32:0]       slot_expiry [SLOTS];
  logic [31:0]       lifetime;

  // stimulus and expectation stores
  otc_pkg::in_t      pending_cmds [$];
  otc_pkg::out_t     expected_results [$];
  logic [CW-1:0]     code_pool [POOL];
  logic [31:0]       wall_seconds;
  int                idle_pct;
  int                items_accepted;
  int                mismatch_count;
  int                cmd_gap;
  int                rsp_gap;
  logic              cmd_taken;
  logic              hold_rsp;

  one_time_code_table_with_expiry #(
    .TABLE_DEPTH(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_item (cmd_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_item (rsp_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // lowest-numbered live slot holding the code, -1 if none
  function automatic int find_slot(input logic [CW-1:0] code);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_code[i] == code) return i;
    end
    return -1;
  endfunction

  // update the predicted table for one command and return its result
  function automatic otc_pkg::out_t apply_command(input otc_pkg::in_t it);
    otc_pkg::out_t     res;
    int                hit;
    logic [32:0]       now;
    logic [CW-1:0]     code;
    res  = '0;
    hit  = -1;
    now  = {1'b0, it.now_seconds};
    code = it.code_symbols & otc_pkg::CODE_MASK;
    case (it.command)
      otc_pkg::CMD_GENERATE: begin
        // a slot that is not live is free whatever its used mark
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_live[i] && hit < 0) hit = i;
        end
        if (hit < 0) begin
          res.status = otc_pkg::ST_NO_FREE;
        end else begin
          slot_live[hit]   = 1'b1;
          slot_used[hit]   = 1'b0;
          slot_code[hit]   = code;
          slot_chan[hit]   = it.channel;
          slot_expiry[hit] = now + {1'b0, lifetime};
        end
      end
      otc_pkg::CMD_ACCEPT: begin
        hit = find_slot(code);
        if (hit < 0) begin
          res.status = otc_pkg::ST_NOT_FOUND;
        end else if (slot_used[hit]) begin
          res.status = otc_pkg::ST_USED;
        end else if (now > slot_expiry[hit]) begin
          slot_live[hit] = 1'b0;
          res.status = otc_pkg::ST_EXPIRED;
        end else begin
          slot_used[hit] = 1'b1;
        end
      end
      otc_pkg::CMD_STATUS: begin
        hit = find_slot(code);
        if (hit < 0) begin
          res.status = otc_pkg::ST_NOT_FOUND;
        end else begin
          res.code_live = (now <= slot_expiry[hit]);
          res.is_used   = slot_used[hit];
        end
      end
      otc_pkg::CMD_CLEANUP: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && (slot_used[i] || now > slot_expiry[i])) slot_live[i] = 1'b0;
        end
      end
      otc_pkg::CMD_COUNT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && slot_chan[i] == it.channel && !slot_used[i] &&
              now <= slot_expiry[i] && res.pending_count != otc_pkg::COUNT_MAX) begin
            res.pending_count = res.pending_count + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic [CW-1:0] code,
                           input logic [2:0] chan, input logic [31:0] now);
    otc_pkg::in_t it;
    it.command      = op;
    it.code_symbols = code;
    it.channel      = chan;
    it.now_seconds  = now;
    pending_cmds.push_back(it);
  endtask

  // one random command; time mostly creeps forward so codes age and expire
  task automatic queue_random_cmd(input int gen_pct, input logic [31:0] step_max);
    int                pick;
    logic [2:0]        op;
    logic [CW-1:0]     code;
    logic [31:0]       now;
    pick = $urandom_range(0, 99);
    if (pick < gen_pct)           op = otc_pkg::CMD_GENERATE;
    else if (pick < gen_pct + 25) op = otc_pkg::CMD_ACCEPT;
    else if (pick < gen_pct + 43) op = otc_pkg::CMD_STATUS;
    else if (pick < gen_pct + 50) op = otc_pkg::CMD_CLEANUP;
    else if (pick < gen_pct + 62) op = otc_pkg::CMD_COUNT;
    else                          op = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) code = {8'($urandom), $urandom};
    else                           code = code_pool[$urandom_range(0, POOL - 1)];
    wall_seconds = wall_seconds + $urandom_range(0, step_max);
    pick = $urandom_range(0, 99);
    if (pick < 3)       now = $urandom;
    else if (pick == 3) now = '0;
    else if (pick == 4) now = '1;
    else                now = wall_seconds;
    queue_cmd(op, code, 3'($urandom_range(0, 7)), now);
  endtask

  // register write, setup then access
  task automatic write_lifetime(input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIFETIME_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    lifetime = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold until every queued item went in and every result came back
  task automatic wait_idle;
    while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  // command driver, fed from the pending queue
  always @(negedge clk) begin : drive_cmd
    otc_pkg::in_t next_item;
    logic         next_valid;
    next_item  = cmd_item;
    next_valid = cmd_valid;
    if (cmd_taken) begin
      next_valid = 1'b0;
      cmd_taken  = 1'b0;
    end
    if (!next_valid && !rst) begin
      if (cmd_gap > 0) begin
        cmd_gap--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        cmd_gap = $urandom_range(0, 4);
      end else if (pending_cmds.size() != 0) begin
        next_item  = pending_cmds.pop_front();
        next_valid = 1'b1;
      end
    end
    cmd_valid <= next_valid;
    cmd_item  <= next_item;
  end

  // result side back-pressure
  always @(negedge clk) begin : drive_rsp_ready
    logic stall;
    stall = 1'b0;
    if (rsp_gap > 0) begin
      rsp_gap--;
      stall = 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      rsp_gap = $urandom_range(0, 4);
      stall   = 1'b1;
    end
    rsp_ready <= !rst && !hold_rsp && !stall;
  end

  // predict on accepted items, check accepted results in order
  always @(posedge clk) begin : watch_ports
    otc_pkg::out_t want;
    if (!rst) begin
      if (cmd_valid && cmd_ready) begin
        expected_results.push_back(apply_command(cmd_item));
        cmd_taken = 1'b1;
        items_accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result: status %0d live %0d used %0d count %0d",
                     rsp_item.status, rsp_item.code_live, rsp_item.is_used,
                     rsp_item.pending_count);
          end
        end else begin
          want = expected_results.pop_front();
          if (rsp_item.status !== want.status || rsp_item.code_live !== want.code_live ||
              rsp_item.is_used !== want.is_used ||
              rsp_item.pending_count !== want.pending_count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: status %0d/%0d live %0d/%0d used %0d/%0d count %0d/%0d",
                       want.status, rsp_item.status, want.code_live, rsp_item.code_live,
                       want.is_used, rsp_item.is_used, want.pending_count,
                       rsp_item.pending_count);
            end
          end
        end
      end
    end
  end

  // one long receiver stall while commands keep coming, so the input backs up
  initial begin : long_hold
    hold_rsp = 1'b0;
    wait (items_accepted >= 650);
    hold_rsp = 1'b1;
    repeat (300) @(posedge clk);
    hold_rsp = 1'b0;
  end

  initial begin : watchdog
    #(CLK_PERIOD * 400000);
    $display("status: fail");
    $finish;
  end

  initial begin : run
    logic [CW-1:0]     all_ones;
    logic [CW-1:0]     other_code;
    logic [31:0]       step_max;
    int                gen_pct;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i]   = 1'b0;
      slot_used[i]   = 1'b0;
      slot_code[i]   = '0;
      slot_chan[i]   = '0;
      slot_expiry[i] = '0;
    end
    lifetime       = otc_pkg::DEFAULT_LIFETIME;
    wall_seconds   = '0;
    idle_pct       = 20;
    items_accepted = 0;
    mismatch_count = 0;
    cmd_gap        = 0;
    rsp_gap        = 0;
    cmd_taken      = 1'b0;
    all_ones       = '1;
    other_code     = {8'($urandom), $urandom};
    for (int i = 0; i < POOL; i++) code_pool[i] = {8'($urandom), $urandom};

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, time extremes, used, expired, duplicates, stale used mark
    queue_cmd(otc_pkg::CMD_COUNT, other_code, 3'd7, 32'd0);
    queue_cmd(otc_pkg::CMD_STATUS, other_code, 3'd0, 32'd0);
    queue_cmd(otc_pkg::CMD_ACCEPT, other_code, 3'd0, 32'd0);
    queue_cmd(otc_pkg::CMD_GENERATE, all_ones, 3'd7, '1);
    queue_cmd(otc_pkg::CMD_STATUS, all_ones, 3'd0, '1);
    queue_cmd(otc_pkg::CMD_COUNT, other_code, 3'd7, '1);
    queue_cmd(otc_pkg::CMD_ACCEPT, all_ones, 3'd0, '1);
    queue_cmd(otc_pkg::CMD_ACCEPT, all_ones, 3'd0, '1);
    queue_cmd(otc_pkg::CMD_STATUS, all_ones, 3'd0, '1);
    queue_cmd(otc_pkg::CMD_GENERATE, '0, 3'd0, 32'd0);
    queue_cmd(otc_pkg::CMD_GENERATE, '0, 3'd0, 32'd100);
    queue_cmd(otc_pkg::CMD_COUNT, other_code, 3'd0, 32'd3600);
    queue_cmd(otc_pkg::CMD_STATUS, '0, 3'd0, 32'd3650);
    queue_cmd(otc_pkg::CMD_ACCEPT, '0, 3'd0, 32'd3650);
    queue_cmd(otc_pkg::CMD_ACCEPT, '0, 3'd0, 32'd3650);
    queue_cmd(otc_pkg::CMD_ACCEPT, '0, 3'd0, 32'd3800);
    queue_cmd(otc_pkg::CMD_CLEANUP, other_code, 3'd0, 32'd3650);
    queue_cmd(otc_pkg::CMD_GENERATE, other_code, 3'd5, 32'd10);
    queue_cmd(otc_pkg::CMD_STATUS, other_code, 3'd0, 32'd10);
    queue_cmd(otc_pkg::CMD_CLEANUP, other_code, 3'd0, '1);
    queue_cmd(otc_pkg::CMD_STATUS, other_code, 3'd0, 32'd10);
    queue_cmd(3'd5, {8'($urandom), $urandom}, 3'($urandom), $urandom);
    queue_cmd(3'd6, {8'($urandom), $urandom}, 3'($urandom), $urandom);
    queue_cmd(3'd7, {8'($urandom), $urandom}, 3'($urandom), $urandom);
    // sender waits for every result before going on
    wait_idle();

    // random phases over several lifetimes, the extremes among them
    for (int phase = 0; phase < 6; phase++) begin
      gen_pct = 30;
      case (phase)
        0: begin
          write_lifetime(32'd0);
          step_max = 32'd1;
          idle_pct = 25;
        end
        1: begin
          write_lifetime('1);
          step_max = '1;
          idle_pct = 0;
        end
        2: begin
          write_lifetime(otc_pkg::DEFAULT_LIFETIME);
          step_max = 32'd300;
          gen_pct  = 55;
          idle_pct = 15;
        end
        3: begin
          write_lifetime($urandom_range(1, 100));
          step_max = 32'd25;
          idle_pct = 50;
        end
        4: begin
          write_lifetime($urandom);
          step_max = (lifetime >> 3) + 32'd1;
          idle_pct = 20;
        end
        default: begin
          write_lifetime($urandom_range(20, 400));
          step_max = 32'd60;
          idle_pct = 0;
        end
      endcase
      for (int i = 0; i < POOL / 3; i++) begin
        code_pool[$urandom_range(0, POOL - 1)] = {8'($urandom), $urandom};
      end
      for (int n = 0; n < PHASE_LEN; n++) queue_random_cmd(gen_pct, step_max);
      wait_idle();
    end

    repeat (DRAIN) @(posedge clk);
    if (expected_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
